/* hdl/bcmp_pkg.sv */
// ----------------------------------------------------------------------------
// bcmp_pkg
// Shared types and constants of the barometer compensation block.
// ----------------------------------------------------------------------------
package bcmp_pkg;

  localparam int unsigned CfgCount    = 6;
  localparam int unsigned CfgIdxWidth = 3;
  localparam int unsigned WordWidth   = 64;
  localparam int unsigned CntWidth    = 6;

  localparam logic [CfgIdxWidth-1:0] RegT1T2 = 3'd0;
  localparam logic [CfgIdxWidth-1:0] RegT3P1 = 3'd1;
  localparam logic [CfgIdxWidth-1:0] RegP2P3 = 3'd2;
  localparam logic [CfgIdxWidth-1:0] RegP4P5 = 3'd3;
  localparam logic [CfgIdxWidth-1:0] RegP6P7 = 3'd4;
  localparam logic [CfgIdxWidth-1:0] RegP8P9 = 3'd5;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_ISSUE  = 6'b000010,
    S_WAIT   = 6'b000100,
    S_DSTART = 6'b001000,
    S_DWAIT  = 6'b010000,
    S_OUT    = 6'b100000
  } state_e;

  typedef enum logic [3:0] {
    STEP_T0 = 4'd0,
    STEP_T1 = 4'd1,
    STEP_T2 = 4'd2,
    STEP_P0 = 4'd3,
    STEP_P1 = 4'd4,
    STEP_P2 = 4'd5,
    STEP_P3 = 4'd6,
    STEP_P4 = 4'd7,
    STEP_P5 = 4'd8,
    STEP_P6 = 4'd9,
    STEP_P7 = 4'd10,
    STEP_P8 = 4'd11,
    STEP_P9 = 4'd12
  } step_e;

endpackage

/* hdl/bcmp_mul.sv */
// ----------------------------------------------------------------------------
// bcmp_mul
// Bit-serial shift-add multiplier, 64 x 64 bits modulo 2^64, one bit a cycle.
// ----------------------------------------------------------------------------
module bcmp_mul (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic        done_o,
  output logic [63:0] prod_o
);

  logic [63:0] a_q, a_d, b_q, b_d, acc_q, acc_d;
  logic [bcmp_pkg::CntWidth-1:0] cnt_q, cnt_d;
  logic busy_q, busy_d, done_q, done_d;

  always_comb begin
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      a_d    = a_i;
      b_d    = b_i;
      acc_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      acc_d = acc_q + (b_q[0] ? a_q : 64'd0);
      a_d   = {a_q[62:0], 1'b0};
      b_d   = {1'b0, b_q[63:1]};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == {bcmp_pkg::CntWidth{1'b1}}) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

/* hdl/bcmp_div.sv */
// ----------------------------------------------------------------------------
// bcmp_div
// Bit-serial restoring divider, signed 64-bit, quotient truncated toward zero.
// ----------------------------------------------------------------------------
module bcmp_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [63:0] den_i,
  output logic        done_o,
  output logic [63:0] quot_o
);

  logic [63:0] q_q, q_d, rem_q, rem_d, den_q, den_d;
  logic [64:0] rem_n;
  logic        ge;
  logic        neg_q, neg_d;
  logic [bcmp_pkg::CntWidth-1:0] cnt_q, cnt_d;
  logic busy_q, busy_d, done_q, done_d;

  always_comb begin
    q_d    = q_q;
    rem_d  = rem_q;
    den_d  = den_q;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    rem_n  = {rem_q, q_q[63]};
    ge     = rem_n >= {1'b0, den_q};
    if (start_i) begin
      q_d    = num_i[63] ? 64'd0 - num_i : num_i;
      den_d  = den_i[63] ? 64'd0 - den_i : den_i;
      neg_d  = num_i[63] ^ den_i[63];
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? 64'(rem_n - {1'b0, den_q}) : rem_n[63:0];
      q_d   = {q_q[62:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == {bcmp_pkg::CntWidth{1'b1}}) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q   <= q_d;
    rem_q <= rem_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? 64'd0 - q_q : q_q;

endmodule

/* hdl/baro_temp_pressure_compensation.sv */
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensation
// Temperature: 3 multiplies from input transfer to output valid.
// Pressure: 10 multiplies and a division; the division is skipped on a zero divisor.
// One sample at a time: a new input is taken only once the last result is in the output register.
// Reset clears trims, fine temperature and all handshake state at once.
// ----------------------------------------------------------------------------
module baro_temp_pressure_compensation (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // raw_sample[19:0], zero pad
  input  logic [0:0]  s_axis_tuser,   // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // temperature_centi[23:0], pressure_q8[49:24], pad
  output logic [1:0]  m_axis_tuser,   // result_kind, divide_by_zero
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  bcmp_pkg::state_e state_q, state_d;
  bcmp_pkg::step_e  step_q, step_d;

  logic [31:0] cfg_q [bcmp_pkg::CfgCount];
  logic [31:0] fine_q, fine_d;
  logic        kind_q, kind_d;
  logic [19:0] adc_q, adc_d;
  logic [63:0] va_q, va_d, vb_q, vb_d, vd_q, vd_d, vp_q, vp_d;
  logic [23:0] rtemp_q, rtemp_d;
  logic [25:0] rpres_q, rpres_d;
  logic        rdz_q, rdz_d;

  logic        ov_q, ov_d;
  logic        okind_q, odz_q;
  logic [23:0] otemp_q;
  logic [25:0] opres_q;

  logic        mul_start, mul_done, div_start, div_done;
  logic [63:0] mul_a, mul_b, prod, quot;

  logic [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic [63:0] v1w, qv, dtmp, tf, tsum, pv, psum;
  logic [31:0] fine_n;

  assign t1 = {48'd0, cfg_q[bcmp_pkg::RegT1T2][15:0]};
  assign t2 = {{48{cfg_q[bcmp_pkg::RegT1T2][31]}}, cfg_q[bcmp_pkg::RegT1T2][31:16]};
  assign t3 = {{48{cfg_q[bcmp_pkg::RegT3P1][15]}}, cfg_q[bcmp_pkg::RegT3P1][15:0]};
  assign p1 = {48'd0, cfg_q[bcmp_pkg::RegT3P1][31:16]};
  assign p2 = {{48{cfg_q[bcmp_pkg::RegP2P3][15]}}, cfg_q[bcmp_pkg::RegP2P3][15:0]};
  assign p3 = {{48{cfg_q[bcmp_pkg::RegP2P3][31]}}, cfg_q[bcmp_pkg::RegP2P3][31:16]};
  assign p4 = {{48{cfg_q[bcmp_pkg::RegP4P5][15]}}, cfg_q[bcmp_pkg::RegP4P5][15:0]};
  assign p5 = {{48{cfg_q[bcmp_pkg::RegP4P5][31]}}, cfg_q[bcmp_pkg::RegP4P5][31:16]};
  assign p6 = {{48{cfg_q[bcmp_pkg::RegP6P7][15]}}, cfg_q[bcmp_pkg::RegP6P7][15:0]};
  assign p7 = {{48{cfg_q[bcmp_pkg::RegP6P7][31]}}, cfg_q[bcmp_pkg::RegP6P7][31:16]};
  assign p8 = {{48{cfg_q[bcmp_pkg::RegP8P9][15]}}, cfg_q[bcmp_pkg::RegP8P9][15:0]};
  assign p9 = {{48{cfg_q[bcmp_pkg::RegP8P9][31]}}, cfg_q[bcmp_pkg::RegP8P9][31:16]};

  assign v1w  = {{32{fine_q[31]}}, fine_q} - 64'd128000;
  assign qv   = 64'($signed(vp_q) >>> 13);
  assign dtmp = 64'(adc_q >> 4) - t1;

  bcmp_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  bcmp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (vd_q),
    .den_i   (vb_q),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  assign mul_start = (state_q == bcmp_pkg::S_ISSUE);
  assign div_start = (state_q == bcmp_pkg::S_DSTART);

  always_comb begin
    mul_a = v1w;
    mul_b = v1w;
    case (step_q)
      bcmp_pkg::STEP_T0: begin
        mul_a = 64'(adc_q >> 3) - (t1 << 1);
        mul_b = t2;
      end
      bcmp_pkg::STEP_T1: begin
        mul_a = dtmp;
        mul_b = dtmp;
      end
      bcmp_pkg::STEP_T2: begin
        mul_a = vb_q;
        mul_b = t3;
      end
      bcmp_pkg::STEP_P0: begin
        mul_a = v1w;
        mul_b = v1w;
      end
      bcmp_pkg::STEP_P1: begin
        mul_a = vd_q;
        mul_b = p6;
      end
      bcmp_pkg::STEP_P2: begin
        mul_a = v1w;
        mul_b = p5;
      end
      bcmp_pkg::STEP_P3: begin
        mul_a = vd_q;
        mul_b = p3;
      end
      bcmp_pkg::STEP_P4: begin
        mul_a = v1w;
        mul_b = p2;
      end
      bcmp_pkg::STEP_P5: begin
        mul_a = (64'd1 << 47) + vb_q;
        mul_b = p1;
      end
      bcmp_pkg::STEP_P6: begin
        mul_a = ((64'd1048576 - 64'(adc_q)) << 31) - va_q;
        mul_b = 64'd3125;
      end
      bcmp_pkg::STEP_P7: begin
        mul_a = p9;
        mul_b = qv;
      end
      bcmp_pkg::STEP_P8: begin
        mul_a = va_q;
        mul_b = qv;
      end
      bcmp_pkg::STEP_P9: begin
        mul_a = p8;
        mul_b = vp_q;
      end
      default: begin
        mul_a = v1w;
        mul_b = v1w;
      end
    endcase
  end

  assign tf     = va_q + 64'($signed(prod) >>> 14);
  assign fine_n = tf[31:0];
  assign tsum   = 64'($signed(({{32{fine_n[31]}}, fine_n} << 2) + {{32{fine_n[31]}}, fine_n}
                  + 64'd128) >>> 8);
  assign pv     = 64'($signed(prod) >>> 19);
  assign psum   = 64'($signed(vp_q + va_q + pv) >>> 8) + (p7 << 4);

  assign s_axis_tready = (state_q == bcmp_pkg::S_IDLE);
  assign cfg_ready_o   = 1'b1;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    fine_d  = fine_q;
    kind_d  = kind_q;
    adc_d   = adc_q;
    va_d    = va_q;
    vb_d    = vb_q;
    vd_d    = vd_q;
    vp_d    = vp_q;
    rtemp_d = rtemp_q;
    rpres_d = rpres_q;
    rdz_d   = rdz_q;
    ov_d    = ov_q && !m_axis_tready;
    case (state_q)
      bcmp_pkg::S_IDLE: begin
        if (s_axis_tvalid) begin
          kind_d  = s_axis_tuser[0];
          adc_d   = s_axis_tdata[19:0];
          step_d  = s_axis_tuser[0] ? bcmp_pkg::STEP_P0 : bcmp_pkg::STEP_T0;
          rtemp_d = '0;
          rpres_d = '0;
          rdz_d   = 1'b0;
          state_d = bcmp_pkg::S_ISSUE;
        end
      end
      bcmp_pkg::S_ISSUE: begin
        state_d = bcmp_pkg::S_WAIT;
      end
      bcmp_pkg::S_WAIT: begin
        if (mul_done) begin
          state_d = bcmp_pkg::S_ISSUE;
          case (step_q)
            bcmp_pkg::STEP_T0: begin
              va_d   = 64'($signed(prod) >>> 11);
              step_d = bcmp_pkg::STEP_T1;
            end
            bcmp_pkg::STEP_T1: begin
              vb_d   = 64'($signed(prod) >>> 12);
              step_d = bcmp_pkg::STEP_T2;
            end
            bcmp_pkg::STEP_T2: begin
              fine_d = fine_n;
              if ($signed(tsum) > 64'sd8388607) begin
                rtemp_d = 24'h7FFFFF;
              end else if ($signed(tsum) < -64'sd8388608) begin
                rtemp_d = 24'h800000;
              end else begin
                rtemp_d = tsum[23:0];
              end
              state_d = bcmp_pkg::S_OUT;
            end
            bcmp_pkg::STEP_P0: begin
              vd_d   = prod;
              step_d = bcmp_pkg::STEP_P1;
            end
            bcmp_pkg::STEP_P1: begin
              va_d   = prod;
              step_d = bcmp_pkg::STEP_P2;
            end
            bcmp_pkg::STEP_P2: begin
              va_d   = va_q + (prod << 17) + (p4 << 35);
              step_d = bcmp_pkg::STEP_P3;
            end
            bcmp_pkg::STEP_P3: begin
              vb_d   = 64'($signed(prod) >>> 8);
              step_d = bcmp_pkg::STEP_P4;
            end
            bcmp_pkg::STEP_P4: begin
              vb_d   = vb_q + (prod << 12);
              step_d = bcmp_pkg::STEP_P5;
            end
            bcmp_pkg::STEP_P5: begin
              vb_d   = 64'($signed(prod) >>> 33);
              step_d = bcmp_pkg::STEP_P6;
              if (64'($signed(prod) >>> 33) == 64'd0) begin
                rdz_d   = 1'b1;
                state_d = bcmp_pkg::S_OUT;
              end
            end
            bcmp_pkg::STEP_P6: begin
              vd_d    = prod;
              state_d = bcmp_pkg::S_DSTART;
            end
            bcmp_pkg::STEP_P7: begin
              va_d   = prod;
              step_d = bcmp_pkg::STEP_P8;
            end
            bcmp_pkg::STEP_P8: begin
              va_d   = 64'($signed(prod) >>> 25);
              step_d = bcmp_pkg::STEP_P9;
            end
            bcmp_pkg::STEP_P9: begin
              if ($signed(psum) < 64'sd0) begin
                rpres_d = '0;
              end else if ($signed(psum) > 64'sd67108863) begin
                rpres_d = 26'h3FFFFFF;
              end else begin
                rpres_d = psum[25:0];
              end
              state_d = bcmp_pkg::S_OUT;
            end
            default: begin
              state_d = bcmp_pkg::S_IDLE;
            end
          endcase
        end
      end
      bcmp_pkg::S_DSTART: begin
        state_d = bcmp_pkg::S_DWAIT;
      end
      bcmp_pkg::S_DWAIT: begin
        if (div_done) begin
          vp_d    = quot;
          step_d  = bcmp_pkg::STEP_P7;
          state_d = bcmp_pkg::S_ISSUE;
        end
      end
      bcmp_pkg::S_OUT: begin
        if (!ov_q || m_axis_tready) begin
          ov_d    = 1'b1;
          state_d = bcmp_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = bcmp_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bcmp_pkg::S_IDLE;
      step_q  <= bcmp_pkg::STEP_T0;
      fine_q  <= '0;
      ov_q    <= 1'b0;
      for (int i = 0; i < bcmp_pkg::CfgCount; i++) begin
        cfg_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      fine_q  <= fine_d;
      ov_q    <= ov_d;
      if (cfg_valid_i && (cfg_index_i < 3'(bcmp_pkg::CfgCount))) begin
        cfg_q[cfg_index_i] <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    adc_q   <= adc_d;
    va_q    <= va_d;
    vb_q    <= vb_d;
    vd_q    <= vd_d;
    vp_q    <= vp_d;
    rtemp_q <= rtemp_d;
    rpres_q <= rpres_d;
    rdz_q   <= rdz_d;
    if (state_q == bcmp_pkg::S_OUT && (!ov_q || m_axis_tready)) begin
      okind_q <= kind_q;
      otemp_q <= rtemp_q;
      opres_q <= rpres_q;
      odz_q   <= rdz_q;
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {6'd0, opres_q, otemp_q};
  assign m_axis_tuser  = {odz_q, okind_q};

`ifndef SYNTHESIS
  a_mul_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> state_q == bcmp_pkg::S_WAIT)
    else $error("multiplier finished outside wait state");

  a_dz_is_pressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0] && m_axis_tdata[49:24] == 26'd0)
    else $error("divide-by-zero flag on a non-zero or temperature result");

  a_temp_no_pressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[49:24] == 26'd0 && !m_axis_tuser[1])
    else $error("temperature result carries pressure data");
`endif

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Checks the barometer compensation block. Directed rows and random samples
// go in over the input stream; each output transfer is compared field by
// field with a predictor of the integer calibration polynomial. Trims are
// rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  localparam bit KindTemp  = 1'b0;
  localparam bit KindPress = 1'b1;
  localparam int unsigned RandItems = 1650;

  typedef struct packed {
    logic        kind;
    logic [23:0] temp_centi;
    logic [25:0] press_q8;
    logic        div_zero;
  } comp_t;

  typedef struct {
    logic        kind;
    logic [19:0] raw;
    bit          has_fixed;
    comp_t       fixed;
  } row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic [0:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [55:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [31:0] cfg_data_i;

  logic [31:0] trim_regs [bcmp_pkg::CfgCount];
  logic [31:0] fine_temp;
  comp_t       pending_results [$];
  int          error_count;
  bit          rx_stall_on;

  baro_temp_pressure_compensation u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic signed [63:0] lo_s(logic [31:0] r);
    return 64'(signed'(r[15:0]));
  endfunction

  function automatic logic signed [63:0] hi_s(logic [31:0] r);
    return 64'(signed'(r[31:16]));
  endfunction

  function automatic comp_t compensate(logic kind, logic [19:0] raw);
    comp_t res;
    logic signed [63:0] t1, t2, t3, a, d, b, t, adc;
    logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, v1, v2, p;
    logic [63:0] ua, ub, q;
    res = '0;
    res.kind = kind;
    adc = 64'(raw);
    if (kind == KindTemp) begin
      t1 = 64'(trim_regs[bcmp_pkg::RegT1T2][15:0]);
      t2 = hi_s(trim_regs[bcmp_pkg::RegT1T2]);
      t3 = lo_s(trim_regs[bcmp_pkg::RegT3P1]);
      a = (((adc >>> 3) - (t1 <<< 1)) * t2) >>> 11;
      d = (adc >>> 4) - t1;
      b = (((d * d) >>> 12) * t3) >>> 14;
      fine_temp = 32'(a + b);
      t = (64'(signed'(fine_temp)) * 5 + 128) >>> 8;
      if (t > 64'sd8388607) t = 64'sd8388607;
      if (t < -64'sd8388608) t = -64'sd8388608;
      res.temp_centi = t[23:0];
    end else begin
      p1 = 64'(trim_regs[bcmp_pkg::RegT3P1][31:16]);
      p2 = lo_s(trim_regs[bcmp_pkg::RegP2P3]);
      p3 = hi_s(trim_regs[bcmp_pkg::RegP2P3]);
      p4 = lo_s(trim_regs[bcmp_pkg::RegP4P5]);
      p5 = hi_s(trim_regs[bcmp_pkg::RegP4P5]);
      p6 = lo_s(trim_regs[bcmp_pkg::RegP6P7]);
      p7 = hi_s(trim_regs[bcmp_pkg::RegP6P7]);
      p8 = lo_s(trim_regs[bcmp_pkg::RegP8P9]);
      p9 = hi_s(trim_regs[bcmp_pkg::RegP8P9]);
      v1 = 64'(signed'(fine_temp)) - 128000;
      v2 = v1 * v1 * p6;
      v2 = v2 + ((v1 * p5) <<< 17);
      v2 = v2 + (p4 <<< 35);
      v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
      v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;
      if (v1 == 0) begin
        res.div_zero = 1'b1;
      end else begin
        p = 64'sd1048576 - adc;
        p = ((p <<< 31) - v2) * 3125;
        ua = p[63] ? -p : p;
        ub = v1[63] ? -v1 : v1;
        q = ua / ub;
        p = (p[63] != v1[63]) ? -q : q;
        v1 = (p9 * (p >>> 13) * (p >>> 13)) >>> 25;
        v2 = (p8 * p) >>> 19;
        p = ((p + v1 + v2) >>> 8) + (p7 <<< 4);
        if (p < 0) p = 0;
        if (p > 64'sd67108863) p = 64'sd67108863;
        res.press_q8 = p[25:0];
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h, want %0h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  task automatic write_trim(logic [2:0] idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx < bcmp_pkg::CfgCount) trim_regs[idx] = data;
    @(posedge clk_i);
  endtask

  task automatic send_sample(logic kind, logic [19:0] raw, bit has_fixed, comp_t fixed);
    comp_t want;
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 6)) @(posedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {4'b0, raw};
    do @(posedge clk_i); while (!s_axis_tready);
    s_axis_tvalid <= 1'b0;
    want = compensate(kind, raw);
    if (has_fixed && want != fixed) report_mismatch("table row", 32'(raw), 32'(kind));
    pending_results.push_back(has_fixed ? fixed : want);
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    comp_t got, want;
    if (rst_ni) begin
      if ($urandom_range(0, 15) == 0) rx_stall_on = !rx_stall_on;
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind       = m_axis_tuser[0];
        got.div_zero   = m_axis_tuser[1];
        got.temp_centi = m_axis_tdata[23:0];
        got.press_q8   = m_axis_tdata[49:24];
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected transfer", 32'(m_axis_tdata), 32'h0);
        end else begin
          want = pending_results.pop_front();
          if (got.kind != want.kind)
            report_mismatch("result_kind", 32'(got.kind), 32'(want.kind));
          if (got.temp_centi != want.temp_centi)
            report_mismatch("temperature_centi", 32'(got.temp_centi), 32'(want.temp_centi));
          if (got.press_q8 != want.press_q8)
            report_mismatch("pressure_q8", 32'(got.press_q8), 32'(want.press_q8));
          if (got.div_zero != want.div_zero)
            report_mismatch("divide_by_zero", 32'(got.div_zero), 32'(want.div_zero));
        end
      end
      m_axis_tready <= rx_stall_on ? ($urandom_range(0, 3) == 0) : 1'b1;
    end
  end

  task automatic load_trims(logic [31:0] r0, r1, r2, r3, r4, r5);
    write_trim(bcmp_pkg::RegT1T2, r0);
    write_trim(bcmp_pkg::RegT3P1, r1);
    write_trim(bcmp_pkg::RegP2P3, r2);
    write_trim(bcmp_pkg::RegP4P5, r3);
    write_trim(bcmp_pkg::RegP6P7, r4);
    write_trim(bcmp_pkg::RegP8P9, r5);
  endtask

  task automatic random_burst(int count);
    int sent;
    logic kind;
    logic [19:0] raw;
    sent = 0;
    while (sent < count) begin
      kind = ($urandom_range(0, 2) != 0);
      case ($urandom_range(0, 5))
        0:       raw = 20'h00000;
        1:       raw = 20'hFFFFF;
        default: raw = 20'($urandom);
      endcase
      send_sample(kind, raw, 1'b0, '0);
      sent++;
    end
  endtask

  initial begin
    row_t rows [$];
    row_t r;
    int i;
    int phase;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    error_count   = 0;
    rx_stall_on   = 1'b0;
    fine_temp     = '0;
    for (i = 0; i < bcmp_pkg::CfgCount; i++) trim_regs[i] = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero trims: temperature 0, pressure divisor 0
    rows.push_back('{KindPress, 20'h00000, 1'b1, '{KindPress, 24'd0, 26'd0, 1'b1}});
    rows.push_back('{KindTemp,  20'hFFFFF, 1'b1, '{KindTemp, 24'd0, 26'd0, 1'b0}});
    rows.push_back('{KindTemp,  20'h00000, 1'b1, '{KindTemp, 24'd0, 26'd0, 1'b0}});
    rows.push_back('{KindPress, 20'hFFFFF, 1'b1, '{KindPress, 24'd0, 26'd0, 1'b1}});
    foreach (rows[k]) send_sample(rows[k].kind, rows[k].raw, rows[k].has_fixed, rows[k].fixed);
    drain();

    // typical datasheet trims
    load_trims(32'h6684_6EA3, 32'h8E6F_0032, 32'h0BD0_D6D3, 32'hFF9C_2747, 32'h3C70_FFF9,
               32'h1770_C6F8);
    rows.delete();
    for (i = 0; i < 16; i++) begin
      r.kind = i[0];
      r.raw = (i < 4) ? ((i < 2) ? 20'h00000 : 20'hFFFFF) : 20'h80000 + 20'(i * 4099);
      r.has_fixed = 1'b0;
      r.fixed = '0;
      rows.push_back(r);
    end
    foreach (rows[k]) send_sample(rows[k].kind, rows[k].raw, rows[k].has_fixed, rows[k].fixed);
    drain();

    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: load_trims('1, '1, '1, '1, '1, '1);
        1: load_trims(32'h8000_FFFF, 32'h0001_8000, 32'h8000_8000, 32'h8000_8000,
                      32'h8000_8000, 32'h8000_8000);
        2: load_trims(32'h7FFF_0000, 32'hFFFF_7FFF, 32'h7FFF_7FFF, 32'h7FFF_7FFF,
                      32'h7FFF_7FFF, 32'h7FFF_7FFF);
        default: load_trims($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      endcase
      if (phase >= 3) write_trim(3'd7, $urandom);
      random_burst(RandItems / 6);
      drain();
    end

    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
